// ===== hw/rtl/emot_pkg.sv =====
package emot_pkg;

    localparam int MAX_EXTENTS_DEF = 64;

    localparam logic [1:0] CMD_WRITE    = 2'd0;
    localparam logic [1:0] CMD_LOOKUP   = 2'd1;
    localparam logic [1:0] CMD_LENGTH   = 2'd2;
    localparam logic [1:0] CMD_TRUNCATE = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [47:0] disk;
        logic [31:0] len;
        logic [31:0] start;
    } t_ext;

endpackage

// ===== hw/rtl/extent_map_overlay_table.sv =====
// Extent map overlay table.
// Slave channel: one beat per command. tuser carries the command (write, lookup,
// length query, truncate); tdata carries offset, length and disk offset.
// Master channel: one beat per command. tuser carries the status (ok, not found,
// table full); tdata carries the found extent and the block length after the
// command.
// The table lives in a two-bank memory with a registered read. A write
// streams the current bank through a scan and builds the new table in the other
// bank, which becomes current unless it overflowed. Lookup and truncate scan the
// current bank, truncate trimming its last kept entry in place.
// A length query, or a write or lookup of zero length, goes straight from idle
// to the result state. A lookup or truncate reads the entries one by one; a
// write reads each entry and pushes its pieces (at most MAX_EXTENTS + 2 pieces).
// Reset empties the table at once; no clearing pass is needed.
// The block takes a new command while a result beat still waits; a stalled
// master side holds the finished result and the next one waits behind it.
module extent_map_overlay_table #(
    parameter int MAX_EXTENTS = emot_pkg::MAX_EXTENTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [1:0]   s_axis_tuser,   // command
    input  logic [111:0] s_axis_tdata,   // offset, length, disk_offset
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [1:0]   m_axis_tuser,   // status
    output logic [151:0] m_axis_tdata    // found_start, found_length,
                                         // found_disk_offset, block_length, zero fill
);
    import emot_pkg::*;

    localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int JW = $clog2(MAX_EXTENTS + 3);
    localparam int MD = 1 << (AW + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_PUSH  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    t_ext mem [0:MD-1];
    t_ext r_rd;

    logic [2:0]    r_state;
    logic [1:0]    r_cmd;
    logic [31:0]   r_off;
    logic [31:0]   r_len;
    logic [47:0]   r_dk;
    logic          r_bank;
    logic [CW-1:0] r_count;
    logic [32:0]   r_end;
    logic [CW-1:0] r_i;
    logic [JW-1:0] r_j;
    logic          r_placed;
    logic          r_tail;
    logic [32:0]   r_wend;
    logic [32:0]   r_tend;
    t_ext          r_pc [0:2];
    logic [2:0]    r_pv;
    logic [1:0]    r_status;
    t_ext          r_found;

    logic          w_we;
    logic [AW:0]   w_waddr;
    t_ext          w_wdata;
    logic [AW:0]   w_raddr;
    logic [32:0]   w_a, w_b, w_s, w_e, w_n;
    t_ext          w_new, w_old, w_left, w_right, w_pick;
    logic [1:0]    w_sel;

    assign w_a = {1'b0, r_rd.start};
    assign w_b = w_a + {1'b0, r_rd.len};
    assign w_s = {1'b0, r_off};
    assign w_e = w_s + {1'b0, r_len};
    assign w_n = {1'b0, r_len};

    always_comb begin
        w_new   = '{disk: r_dk, len: r_len, start: r_off};
        w_old   = r_rd;
        w_left  = '{disk: r_rd.disk, len: r_off - r_rd.start, start: r_rd.start};
        w_right = '{disk: r_rd.disk + {15'd0, w_e - w_a},
                    len: w_b[31:0] - w_e[31:0], start: w_e[31:0]};
    end

    always_comb begin
        if (r_pv[0]) begin
            w_sel = 2'd0;
        end else if (r_pv[1]) begin
            w_sel = 2'd1;
        end else begin
            w_sel = 2'd2;
        end
        w_pick = r_pc[w_sel];
    end

    assign w_raddr = {r_bank, r_i[AW-1:0]};

    always_comb begin
        w_we    = 1'b0;
        w_waddr = {~r_bank, r_j[AW-1:0]};
        w_wdata = w_pick;
        if (r_state == S_PUSH) begin
            w_we = (r_pv != 3'd0) && (r_j < JW'(MAX_EXTENTS));
        end else if (r_state == S_EVAL && r_cmd == CMD_TRUNCATE) begin
            w_waddr = {r_bank, r_i[AW-1:0]};
            w_wdata = '{disk: r_rd.disk, len: r_len - r_rd.start, start: r_rd.start};
            w_we    = (w_a < w_n) && (w_b > w_n);
        end
    end

    // Table memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd <= mem[w_raddr];
    end

    assign s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_bank        <= 1'b0;
            r_count       <= '0;
            r_end         <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            // A result loaded in S_FIN takes the place of the one leaving.
            if (m_axis_tvalid && m_axis_tready && r_state != S_FIN) begin
                m_axis_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd    <= s_axis_tuser;
                        r_off    <= s_axis_tdata[31:0];
                        r_len    <= s_axis_tdata[63:32];
                        r_dk     <= s_axis_tdata[111:64];
                        r_i      <= '0;
                        r_j      <= '0;
                        r_placed <= 1'b0;
                        r_tail   <= 1'b0;
                        r_tend   <= '0;
                        r_found  <= '0;
                        if (s_axis_tuser == CMD_LENGTH) begin
                            r_status <= ST_OK;
                            r_state  <= S_FIN;
                        end else if (s_axis_tuser != CMD_TRUNCATE
                                     && s_axis_tdata[63:32] == 32'd0) begin
                            // An empty write changes nothing; an empty lookup hits nothing.
                            r_status <= (s_axis_tuser == CMD_LOOKUP) ? ST_NOT_FOUND
                                                                     : ST_OK;
                            r_state  <= S_FIN;
                        end else begin
                            r_status <= ST_OK;
                            r_state  <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE: begin
                    if (r_i < r_count) begin
                        r_state <= S_EVAL;
                    end else begin
                        case (r_cmd)
                            CMD_WRITE: begin
                                if (!r_placed) begin
                                    r_pc[0] <= w_new;
                                    r_pv    <= 3'b001;
                                    r_tail  <= 1'b1;
                                    r_state <= S_PUSH;
                                end else if (r_j > JW'(MAX_EXTENTS)) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_FIN;
                                end else begin
                                    r_bank  <= ~r_bank;
                                    r_count <= r_j[CW-1:0];
                                    r_end   <= r_wend;
                                    r_state <= S_FIN;
                                end
                            end
                            CMD_LOOKUP: begin
                                r_status <= ST_NOT_FOUND;
                                r_state  <= S_FIN;
                            end
                            CMD_TRUNCATE: begin
                                r_end   <= r_tend;
                                r_state <= S_FIN;
                            end
                            default: begin
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_EVAL: begin
                    case (r_cmd)
                        CMD_WRITE: begin
                            if (w_b <= w_s || w_a >= w_e) begin
                                r_pc[0] <= w_new;
                                r_pc[1] <= w_old;
                                r_pv    <= {1'b0, 1'b1, !r_placed && w_a >= w_s};
                                if (w_a >= w_s) begin
                                    r_placed <= 1'b1;
                                end
                            end else begin
                                r_pc[0]  <= w_left;
                                r_pc[1]  <= w_new;
                                r_pc[2]  <= w_right;
                                r_pv     <= {w_b > w_e && !w_e[32], !r_placed, w_a < w_s};
                                r_placed <= 1'b1;
                            end
                            r_state <= S_PUSH;
                        end
                        CMD_LOOKUP: begin
                            if (w_b > w_s && w_a < w_e) begin
                                r_found <= r_rd;
                                r_state <= S_FIN;
                            end else begin
                                r_i     <= r_i + 1'b1;
                                r_state <= S_ISSUE;
                            end
                        end
                        default: begin
                            if (w_a >= w_n) begin
                                r_count <= r_i;
                                r_end   <= r_tend;
                                r_state <= S_FIN;
                            end else begin
                                r_tend  <= (w_b > w_n) ? w_n : w_b;
                                r_i     <= r_i + 1'b1;
                                r_state <= S_ISSUE;
                            end
                        end
                    endcase
                end
                S_PUSH: begin
                    if (r_pv != 3'd0) begin
                        r_pv[w_sel] <= 1'b0;
                        r_j         <= r_j + 1'b1;
                        r_wend      <= {1'b0, w_pick.start} + {1'b0, w_pick.len};
                    end else begin
                        if (r_tail) begin
                            r_placed <= 1'b1;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                        r_state <= S_ISSUE;
                    end
                end
                S_FIN: begin
                    if (!m_axis_tvalid || m_axis_tready) begin
                        m_axis_tvalid <= 1'b1;
                        m_axis_tuser  <= r_status;
                        m_axis_tdata  <= {7'd0, r_end, r_found.disk, r_found.len,
                                          r_found.start};
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
